// File: src/tie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tie_pkg
// Shared types and constants of the execute unit.
// ----------------------------------------------------------------------------
package tie_pkg;
    localparam int DataWordsDef = 1024;
    localparam int DataBaseDef  = 16384;
    localparam int RegCountDef  = 9;
    localparam int XLEN         = 32;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
        OP_AND = 4'd5, OP_OR  = 4'd6, OP_NOT = 4'd7, OP_CMP = 4'd8, OP_JMP = 4'd9
    } op_t;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ADDR = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;

    typedef struct packed {
        logic start;
        logic [XLEN-1:0] dividend;
        logic [XLEN-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [XLEN-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: src/tie_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tie_divider
// Signed restoring divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tie_divider
    import tie_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [XLEN-1:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg, neg_reg, done_reg;
    logic [XLEN:0]   trial;
    logic [XLEN-1:0] rem_sh;

    assign rem_sh = {rem_reg[XLEN-2:0], quo_reg[XLEN-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(XLEN);
                rem_reg  <= '0;
                quo_reg  <= req.dividend[XLEN-1] ? -req.dividend : req.dividend;
                dvs_reg  <= req.divisor[XLEN-1] ? -req.divisor : req.divisor;
                neg_reg  <= req.dividend[XLEN-1] ^ req.divisor[XLEN-1];
            end else if (busy_reg) begin
                if (trial[XLEN]) begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[XLEN-2:0], 1'b0};
                end else begin
                    rem_reg <= trial[XLEN-1:0];
                    quo_reg <= {quo_reg[XLEN-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -quo_reg : quo_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> $past(busy_reg)) else $error("done without busy");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != 6'd0)) else $error("counter underflow");
    a_busy_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> !busy_reg) else $error("busy with done");
endmodule
`default_nettype wire

// File: src/toy_isa_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toy_isa_execute_unit
// Executes one decoded instruction per word over a register file, a data
// memory, a compare flag and a program counter.
// Divide runs on a serial divider. One word in flight at a time: a new word is
// taken only after the previous result has been accepted.
// Reset: clears state and registers, then a clearing pass zeroes every word of
// data memory before the first word is taken.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit
    import tie_pkg::*;
#(
    parameter int DATA_WORDS = DataWordsDef,
    parameter int DATA_BASE  = DataBaseDef
)(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_req_type,
    input  wire logic [3:0]         s_dest_select,
    input  wire logic [3:0]         s_source_select,
    input  wire logic signed [15:0] s_immediate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_program_counter,
    output logic signed [1:0]       m_compare_flag,
    output logic signed [31:0]      m_written_value,
    output logic                    m_wrote_memory,
    output logic [1:0]              m_error_code
);
    localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int RC = RegCountDef;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_MEMRD, S_EXEC, S_DIV, S_DWAIT, S_OUT
    } state_t;

    state_t          state_reg;
    logic [AW:0]     clr_reg;
    logic [31:0]     rf_reg [RC];
    logic [31:0]     mem [DATA_WORDS];
    logic [31:0]     mem_q;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [31:0]     mem_wd;
    logic [AW-1:0]   ra_reg;
    logic [3:0]      op_reg, d_reg, s_reg;
    logic [31:0]     imm_reg, a_reg, p_reg;
    logic            aok_reg;
    logic [1:0]      flag_reg;
    logic [15:0]     pc_reg;
    logic [31:0]     wv_reg;
    logic            wm_reg;
    logic [1:0]      err_reg;
    div_req_t        dreq;
    div_rsp_t        drsp;

    tie_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // address check on pointer p_reg
    logic signed [33:0] off;
    logic               addr_ok;
    assign off     = 34'(signed'(p_reg)) - 34'(DATA_BASE);
    assign addr_ok = !off[33] && (off[33:1] < 33'(DATA_WORDS));

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_q <= mem[ra_reg];
    end

    logic d_ok, s_reg_ok, d14, d58, s14, s58;
    assign d_ok     = d_reg < 4'(RC);
    assign s_reg_ok = s_reg < 4'(RC);
    assign d14 = d_reg >= 4'd1 && d_reg <= 4'd4;
    assign d58 = d_reg >= 4'd5 && d_reg <= 4'd8;
    assign s14 = s_reg >= 4'd1 && s_reg <= 4'd4;
    assign s58 = s_reg >= 4'd5 && s_reg <= 4'd8;

    // does this op read memory via the source pointer
    logic need_src_mem;
    always_comb begin
        need_src_mem = 1'b0;
        case (op_t'(op_reg))
            OP_MOV: need_src_mem = d_ok && d14 && s58;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: need_src_mem = d_ok && s58;
            OP_AND, OP_OR, OP_CMP: need_src_mem = d_ok && s_reg != 4'd0 && s_reg_ok;
            OP_NOT: need_src_mem = s_reg != 4'd0 && d_reg == 4'd0 && s_reg_ok;
            default: need_src_mem = 1'b0;
        endcase
    end

    logic [31:0] bop, mres;
    logic signed [32:0] ca, cb;
    assign bop = (s_reg == 4'd0) ? imm_reg : mem_q;
    assign mres = 32'(a_reg * bop);
    assign ca = 33'(signed'(a_reg));
    assign cb = 33'(signed'(bop));

    logic jtake;
    assign jtake = s_reg == 4'd0 || (s_reg == 4'd1 && flag_reg == 2'b00)
        || (s_reg == 4'd2 && flag_reg == 2'b01) || (s_reg == 4'd3 && flag_reg == 2'b11);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            flag_reg  <= 2'b00;
            pc_reg    <= '0;
            mem_we    <= 1'b0;
            dreq.start <= 1'b0;
            for (int i = 0; i < RC; i++) rf_reg[i] <= '0;
        end else begin
            mem_we     <= 1'b0;
            dreq.start <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    mem_we <= 1'b1;
                    mem_wa <= clr_reg[AW-1:0];
                    mem_wd <= '0;
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DATA_WORDS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg  <= s_req_type;
                        d_reg   <= s_dest_select;
                        s_reg   <= s_source_select;
                        imm_reg <= 32'(s_immediate);
                        wv_reg  <= '0;
                        wm_reg  <= 1'b0;
                        err_reg <= ERR_NONE;
                        state_reg <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    a_reg <= (d_reg < 4'(RC)) ? rf_reg[d_reg] : '0;
                    // mov stores use the dest pointer; every other memory access uses the source pointer
                    if (op_t'(op_reg) == OP_MOV && d58 && s14)
                        p_reg <= rf_reg[d_reg];
                    else
                        p_reg <= (s_reg < 4'(RC)) ? rf_reg[s_reg] : '0;
                    state_reg <= S_MEMRD;
                end
                S_MEMRD: begin
                    aok_reg <= addr_ok;
                    ra_reg  <= AW'(off[33:1]);
                    state_reg <= S_EXEC;
                    if (!need_src_mem) state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    // memory word lands in mem_q at this edge
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    state_reg <= S_OUT;
                    case (op_t'(op_reg))
                        OP_MOV: begin
                            if (d_ok) begin
                                if (s_reg == 4'd0) begin
                                    rf_reg[d_reg] <= imm_reg; wv_reg <= imm_reg;
                                end else if (d14 && s58) begin
                                    if (aok_reg) begin
                                        rf_reg[d_reg] <= mem_q; wv_reg <= mem_q;
                                    end else err_reg <= ERR_ADDR;
                                end else if (d58 && s14) begin
                                    if (aok_reg) begin
                                        mem_we <= 1'b1; mem_wa <= ra_reg;
                                        mem_wd <= rf_reg[s_reg];
                                        wv_reg <= rf_reg[s_reg]; wm_reg <= 1'b1;
                                    end else err_reg <= ERR_ADDR;
                                end
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (d_ok && !s14 && (s_reg == 4'd0 || s_reg_ok)) begin
                                if (s_reg != 4'd0 && !aok_reg) err_reg <= ERR_ADDR;
                                else if (op_t'(op_reg) == OP_ADD) begin
                                    rf_reg[d_reg] <= a_reg + bop; wv_reg <= a_reg + bop;
                                end else if (op_t'(op_reg) == OP_SUB) begin
                                    rf_reg[d_reg] <= a_reg - bop; wv_reg <= a_reg - bop;
                                end else if (op_t'(op_reg) == OP_MUL) begin
                                    rf_reg[d_reg] <= mres; wv_reg <= mres;
                                end else if (bop == '0) err_reg <= ERR_DIV0;
                                else begin
                                    dreq.start    <= 1'b1;
                                    dreq.dividend <= a_reg;
                                    dreq.divisor  <= bop;
                                    state_reg <= S_DWAIT;
                                end
                            end
                        end
                        OP_AND, OP_OR: begin
                            if (d_ok && (s_reg == 4'd0 || s_reg_ok)) begin
                                if (s_reg != 4'd0 && !aok_reg) err_reg <= ERR_ADDR;
                                else begin
                                    rf_reg[d_reg] <= 32'((op_t'(op_reg) == OP_AND)
                                        ? (a_reg != 0 && bop != 0) : (a_reg != 0 || bop != 0));
                                    wv_reg <= 32'((op_t'(op_reg) == OP_AND)
                                        ? (a_reg != 0 && bop != 0) : (a_reg != 0 || bop != 0));
                                end
                            end
                        end
                        OP_NOT: begin
                            if (s_reg == 4'd0) begin
                                if (d_ok) begin
                                    rf_reg[d_reg] <= 32'(a_reg == 0); wv_reg <= 32'(a_reg == 0);
                                end
                            end else if (d_reg == 4'd0 && s_reg_ok) begin
                                if (aok_reg) begin
                                    mem_we <= 1'b1; mem_wa <= ra_reg;
                                    mem_wd <= 32'(mem_q == 0);
                                    wv_reg <= 32'(mem_q == 0); wm_reg <= 1'b1;
                                end else err_reg <= ERR_ADDR;
                            end
                        end
                        OP_CMP: begin
                            if (d_ok && (s_reg == 4'd0 || s_reg_ok)) begin
                                if (s_reg != 4'd0 && !aok_reg) err_reg <= ERR_ADDR;
                                else flag_reg <= (ca == cb) ? 2'b00
                                               : ((ca < cb) ? 2'b11 : 2'b01);
                            end
                        end
                        OP_JMP: begin
                            if (jtake) pc_reg <= pc_reg + imm_reg[15:0] - 16'd4;
                        end
                        default: begin
                        end
                    endcase
                end
                S_DWAIT: begin
                    if (drsp.done) begin
                        rf_reg[d_reg] <= drsp.quotient;
                        wv_reg    <= drsp.quotient;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready           = state_reg == S_IDLE;
    assign m_valid           = state_reg == S_OUT;
    assign m_program_counter = pc_reg;
    assign m_compare_flag    = flag_reg;
    assign m_written_value   = wv_reg;
    assign m_wrote_memory    = wm_reg;
    assign m_error_code      = err_reg;

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready with pending word");
    a_err_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |-> (m_written_value == '0 && !m_wrote_memory))
        else $error("write despite error");
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_compare_flag != 2'b10) else $error("bad flag code");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Execute unit testbench
// Drives decoded instruction words through the valid/ready handshake with
// random gaps and result stalls, predicts registers, data memory, flag and
// counter in a scoreboard class, and checks every result word field by field.
// ----------------------------------------------------------------------------
module tb;
    import tie_pkg::*;

    localparam int NWORDS = 1024;
    localparam int BASE   = 16384;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [15:0] pc;
        logic [1:0]  flag;
        logic [31:0] wval;
        logic        wmem;
        logic [1:0]  err;
    } exec_res_t;

    class exec_scoreboard;
        logic [31:0] regs [9];
        logic [31:0] dmem [NWORDS];
        logic [1:0]  flag;
        logic [15:0] pc;
        exec_res_t   pending [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            flag = '0;
            pc = '0;
            errors = 0;
        endfunction

        function bit addr_ok(logic [31:0] ptr, output int idx);
            longint off;
            off = longint'($signed(ptr)) - BASE;
            idx = int'(off / 2);
            return off >= 0 && off / 2 < NWORDS;
        endfunction

        // 0 ok, 1 address error, 3 nothing
        function int operand(logic [3:0] s, logic [31:0] imm, output logic [31:0] v);
            int idx;
            v = '0;
            if (s == 0) begin
                v = imm;
                return 0;
            end
            if (s >= 9) return 3;
            if (!addr_ok(regs[s], idx)) return 1;
            v = dmem[idx];
            return 0;
        endfunction

        function void note_word(logic [3:0] op, logic [3:0] d, logic [3:0] s,
                                logic [15:0] imm16);
            logic [31:0] imm, b, a, res, wv;
            logic wm;
            logic [1:0] er;
            int idx, r;
            bit dv;
            imm = {{16{imm16[15]}}, imm16};
            wv = '0; wm = 0; er = ERR_NONE; dv = d < 9;
            case (op)
                OP_MOV: if (dv) begin
                    if (s == 0) begin
                        regs[d] = imm; wv = imm;
                    end else if (d >= 1 && d <= 4 && s >= 5 && s <= 8) begin
                        if (addr_ok(regs[s], idx)) begin
                            regs[d] = dmem[idx]; wv = dmem[idx];
                        end else er = ERR_ADDR;
                    end else if (d >= 5 && d <= 8 && s >= 1 && s <= 4) begin
                        if (addr_ok(regs[d], idx)) begin
                            dmem[idx] = regs[s]; wv = regs[s]; wm = 1;
                        end else er = ERR_ADDR;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (dv && !(s >= 1 && s <= 4)) begin
                    r = operand(s, imm, b);
                    if (r == 1) er = ERR_ADDR;
                    else if (r == 0) begin
                        a = regs[d];
                        if (op == OP_DIV && b == 0) er = ERR_DIV0;
                        else begin
                            case (op)
                                OP_ADD: res = a + b;
                                OP_SUB: res = a - b;
                                OP_MUL: res = a * b;
                                default: res = 32'(longint'($signed(a)) /
                                                   longint'($signed(b)));
                            endcase
                            regs[d] = res; wv = res;
                        end
                    end
                end
                OP_AND, OP_OR: if (dv) begin
                    r = operand(s, imm, b);
                    if (r == 1) er = ERR_ADDR;
                    else if (r == 0) begin
                        wv = (op == OP_AND) ? 32'((regs[d] != 0) && (b != 0))
                                            : 32'((regs[d] != 0) || (b != 0));
                        regs[d] = wv;
                    end
                end
                OP_NOT: begin
                    if (s == 0) begin
                        if (dv) begin
                            wv = 32'(regs[d] == 0); regs[d] = wv;
                        end
                    end else if (d == 0 && s < 9) begin
                        if (addr_ok(regs[s], idx)) begin
                            wv = 32'(dmem[idx] == 0); dmem[idx] = wv; wm = 1;
                        end else er = ERR_ADDR;
                    end
                end
                OP_CMP: if (dv) begin
                    r = operand(s, imm, b);
                    if (r == 1) er = ERR_ADDR;
                    else if (r == 0) begin
                        if ($signed(regs[d]) == $signed(b)) flag = 2'b00;
                        else if ($signed(regs[d]) < $signed(b)) flag = 2'b11;
                        else flag = 2'b01;
                    end
                end
                OP_JMP: begin
                    if (s == 0 || (s == 1 && flag == 2'b00) || (s == 2 && flag == 2'b01)
                        || (s == 3 && flag == 2'b11))
                        pc = pc + imm16 - 16'd4;
                end
                default: ;
            endcase
            pending.push_back('{pc, flag, wv, wm, er});
        endfunction

        function void check_word(exec_res_t got);
            exec_res_t exp;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.pc != exp.pc) begin
                $error("program_counter exp %h got %h", exp.pc, got.pc); errors++;
            end
            if (got.flag != exp.flag) begin
                $error("compare_flag exp %h got %h", exp.flag, got.flag); errors++;
            end
            if (got.wval != exp.wval) begin
                $error("written_value exp %h got %h", exp.wval, got.wval); errors++;
            end
            if (got.wmem != exp.wmem) begin
                $error("wrote_memory exp %b got %b", exp.wmem, got.wmem); errors++;
            end
            if (got.err != exp.err) begin
                $error("error_code exp %d got %d", exp.err, got.err); errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, m_ready = 0;
    logic [3:0] s_req_type = 0, s_dest_select = 0, s_source_select = 0;
    logic signed [15:0] s_immediate = 0;
    logic s_ready, m_valid, m_wrote_memory;
    logic [15:0] m_program_counter;
    logic signed [1:0] m_compare_flag;
    logic signed [31:0] m_written_value;
    logic [1:0] m_error_code;

    exec_scoreboard sb = new();
    bit  hold_off = 0;
    int  cycles = 0;

    always #10 aclk = ~aclk;

    toy_isa_execute_unit uut (.*);

    // returns at the accepting edge; valid stays up until the next call
    task automatic send_word(logic [3:0] op, logic [3:0] d, logic [3:0] s,
                             logic [15:0] imm);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1; s_req_type <= op; s_dest_select <= d;
        s_source_select <= s; s_immediate <= imm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(op, d, s, imm);
    endtask

    // pointer into data memory: mostly in range, sometimes off either end
    function automatic logic [15:0] ptr_value();
        case ($urandom_range(0, 9))
            0: return 16'(BASE - 2);
            1: return 16'(BASE + 2 * NWORDS);
            2: return 16'(BASE + 2 * NWORDS - 1);
            3: return 16'($urandom);
            default: return 16'(BASE + $urandom_range(0, 15) * 2 + $urandom_range(0, 1));
        endcase
    endfunction

    task automatic random_word();
        logic [3:0] op, d, s;
        logic [15:0] imm;
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) begin
            op = 4'($urandom); d = 4'($urandom); s = 4'($urandom); imm = 16'($urandom);
        end else if (k < 4) begin
            send_word(OP_MOV, 4'($urandom_range(5, 8)), 4'd0, ptr_value());
            return;
        end else begin
            op = 4'($urandom_range(0, 9));
            d = 4'($urandom_range(0, 8));
            s = 4'($urandom_range(0, 8));
            if ($urandom_range(0, 2) == 0) s = 0;
            imm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
            if (op == OP_JMP) s = 4'($urandom_range(0, 5));
        end
        send_word(op, d, s, imm);
    endtask

    initial begin
        int wait_n;
        forever begin
            wait_n = $urandom_range(0, 13);
            @(negedge aclk);
            if (wait_n != 0 || hold_off) begin
                m_ready <= 0;
                repeat (wait_n) @(negedge aclk);
                while (hold_off) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(aresetn && m_valid)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word('{m_program_counter, m_compare_flag, m_written_value,
                            m_wrote_memory, m_error_code});
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed
        send_word(OP_MOV, 4'd1, 4'd0, 16'h7fff);
        send_word(OP_MOV, 4'd2, 4'd0, 16'h8000);
        send_word(OP_MUL, 4'd2, 4'd0, 16'h0001);
        send_word(OP_MOV, 4'd5, 4'd0, 16'(BASE));
        send_word(OP_MOV, 4'd5, 4'd2, 16'd0);
        send_word(OP_MOV, 4'd3, 4'd5, 16'd0);
        send_word(OP_ADD, 4'd1, 4'd5, 16'd0);
        send_word(OP_SUB, 4'd1, 4'd0, 16'hffff);
        send_word(OP_DIV, 4'd1, 4'd0, 16'd0);
        send_word(OP_MOV, 4'd4, 4'd0, 16'h8000);
        send_word(OP_MUL, 4'd4, 4'd0, 16'h0000);
        send_word(OP_MOV, 4'd4, 4'd0, 16'h4000);
        send_word(OP_MUL, 4'd4, 4'd0, 16'hfffe);
        send_word(OP_DIV, 4'd4, 4'd0, 16'hffff);
        send_word(OP_AND, 4'd1, 4'd0, 16'd0);
        send_word(OP_OR,  4'd1, 4'd6, 16'd0);
        send_word(OP_NOT, 4'd0, 4'd5, 16'd0);
        send_word(OP_NOT, 4'd1, 4'd0, 16'd0);
        send_word(OP_MOV, 4'd6, 4'd0, 16'(BASE - 2));
        send_word(OP_MOV, 4'd6, 4'd1, 16'd0);
        send_word(OP_CMP, 4'd2, 4'd0, 16'h7fff);
        send_word(OP_JMP, 4'd15, 4'd3, 16'h8000);
        send_word(OP_JMP, 4'd0, 4'd0, 16'h7fff);
        send_word(4'd12, 4'd9, 4'd15, 16'h1234);
        send_word(OP_ADD, 4'd15, 4'd0, 16'd1);
        // long receiver hold-off while further words are offered
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            for (n = 0; n < 10; n++) random_word();
        join
        for (n = 0; n < 540; n++) random_word();
        @(negedge aclk);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
